/* design/rtlm_pkg.sv */
// Shared constants, codes and item types of the round trip latency monitor.
package rtlm_pkg;

   localparam int STAMP_DEPTH_DEF = 128;
   localparam int HIST_BINS_DEF   = 1024;

   // Depth of the queue between the front and the back part.
   localparam int QUEUE_DEPTH = 8;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int NS_W   = 30;
   localparam int SEQ_W  = 32;
   localparam int MAC_W  = 48;
   localparam int BIN_W  = 10;
   localparam int CNT_W  = 32;
   localparam int SUM_W  = 64;
   localparam int KIND_W = 2;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 48;

   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 256;

   localparam logic [NS_W-1:0]   LAT_MAX  = 30'd999999999;
   localparam logic signed [31:0] NS_PER_S = 32'sd1000000000;

   // Nanoseconds to microseconds: (lat * DIV_US_MULT) >> DIV_US_SHIFT is exact for 30-bit lat.
   localparam int              DIV_US_SHIFT = 40;
   localparam logic [30:0]     DIV_US_MULT  = 31'd1099511628;
   localparam int              US_W         = 20;

   localparam logic [KIND_W-1:0] REQ_SEND = 2'd0;
   localparam logic [KIND_W-1:0] REQ_RECV = 2'd1;
   localparam logic [KIND_W-1:0] REQ_READ = 2'd2;

   typedef enum logic [CSR_AW-1:0] {
      CSR_PEER_MAC    = 2'd0,
      CSR_HIST_ENABLE = 2'd1,
      CSR_MAX_COUNT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [MAC_W-1:0] peer_mac;
      logic             hist_enable;
      logic [CNT_W-1:0] max_count;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              ok;
      logic [NS_W-1:0]   tns;
      logic [NS_W-1:0]   hold;
      logic [BIN_W-1:0]  bin_index;
   } front_meta_type;

   typedef struct packed {
      front_meta_type  meta;
      logic [NS_W-1:0] stamp;
   } q_item_type;

endpackage

/* design/round_trip_latency_monitor_unit.sv */
// Top level of the round trip latency monitor: configuration registers and the two halves.
//
// The monitor takes one item per clock cycle while req_tready is high and returns one
// result per item, in order. An item passes through three front stages (sequence to slot
// reduction and the stamp table access), the queue, and six back stages (latency
// arithmetic, statistics, the microsecond division by reciprocal multiplication, the
// histogram read-modify-write and the result register). The histogram update is a
// read-modify-write on one RAM with forwarding between neighbouring items, so equal
// bins in consecutive items do not slow the stream. After reset both tables are swept
// to zero, one entry per cycle; req_tready stays low until both sweeps are done.
// Configuration writes are taken at any time and should be made while idle.
module round_trip_latency_monitor_unit
   import rtlm_pkg::*;
#(
   parameter int STAMP_DEPTH = STAMP_DEPTH_DEF,
   parameter int HIST_BINS   = HIST_BINS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [CSR_DW-1:0]      csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // seq_num, time_ns, src_mac, hold_ns, tag_ok, bin_index
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  logic [KIND_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // accepted, latency_ns, neg_flag, min_ns, max_ns, sum_ns, reply_count,
   // overflow_count, done_res, bin_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cfg_type           cfg_ff;
   logic              back_clearing;
   logic [QCNT_W-1:0] q_count;
   logic              push;
   q_item_type        push_item;
   logic              pop;
   q_item_type        q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PEER_MAC:    cfg_ff.peer_mac    <= csr_wdata[MAC_W-1:0];
            CSR_HIST_ENABLE: cfg_ff.hist_enable <= csr_wdata[0];
            CSR_MAX_COUNT:   cfg_ff.max_count   <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rtlm_front #(
      .STAMP_DEPTH (STAMP_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .back_clearing (back_clearing),
      .q_count       (q_count),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .push          (push),
      .push_item     (push_item)
   );

   rtlm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (q_head),
      .count     (q_count)
   );

   rtlm_back #(
      .HIST_BINS (HIST_BINS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_count    (q_count),
      .q_head     (q_head),
      .pop        (pop),
      .clearing   (back_clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* design/rtlm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module rtlm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // A read at the address being written returns the old content.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

/* design/rtlm_front.sv */
// Front part: accepts items, checks the peer, finds the stamp slot and keeps the stamp table.
module rtlm_front
   import rtlm_pkg::*;
#(
   parameter int STAMP_DEPTH = STAMP_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   back_clearing,
   input  logic [QCNT_W-1:0]      q_count,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]      req_tuser,
   output logic                   push,
   output q_item_type             push_item
);

   localparam int SAW   = $clog2(STAMP_DEPTH);
   localparam int MOD_K = 29 + SAW;
   localparam logic [28:0] MOD_C = 29'(64'd65536 % STAMP_DEPTH);
   localparam logic [30:0] MOD_M = 31'(((64'd1 << MOD_K) + STAMP_DEPTH - 1) / STAMP_DEPTH);
   localparam logic [28:0] MOD_D = 29'(STAMP_DEPTH);

   logic [SEQ_W-1:0] in_seq;
   logic [MAC_W-1:0] in_mac;
   logic             in_tag;
   front_meta_type   in_meta;
   logic [28:0]      x_in;
   logic             accept;
   logic [QCNT_W:0]  occupancy;

   logic             f1_valid_ff;
   logic [28:0]      f1_x_ff;
   front_meta_type   f1_meta_ff;
   logic [59:0]      f1_prod;

   logic             f2_valid_ff;
   logic [28:0]      f2_x_ff;
   logic [28:0]      f2_q_ff;
   front_meta_type   f2_meta_ff;
   logic [28:0]      f2_rem;
   logic [SAW-1:0]   f2_slot;

   logic             f3_valid_ff;
   front_meta_type   f3_meta_ff;

   logic             clr_active_ff;
   logic [SAW-1:0]   clr_addr_ff;

   logic             stamp_we;
   logic [SAW-1:0]   stamp_waddr;
   logic [NS_W-1:0]  stamp_wdata;
   logic [NS_W-1:0]  stamp_rdata;

   assign in_seq            = req_tdata[31:0];
   assign in_meta.tns       = req_tdata[61:32];
   assign in_mac            = req_tdata[109:62];
   assign in_meta.hold      = req_tdata[139:110];
   assign in_tag            = req_tdata[140];
   assign in_meta.bin_index = req_tdata[150:141];
   assign in_meta.kind      = req_tuser;
   assign in_meta.ok        = (in_mac == cfg.peer_mac) && in_tag;

   // Every item in the front pipeline has a queue place reserved for it.
   assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(f1_valid_ff)
                    + (QCNT_W+1)'(f2_valid_ff) + (QCNT_W+1)'(f3_valid_ff);
   assign req_tready = !clr_active_ff && !back_clearing
                     && (occupancy < (QCNT_W+1)'(QUEUE_DEPTH));
   assign accept = req_tvalid && req_tready;

   // seq mod depth: fold the upper half in, then divide by reciprocal multiplication.
   assign x_in    = 29'(in_seq[31:16]) * MOD_C + 29'(in_seq[15:0]);
   assign f1_prod = 60'(f1_x_ff) * 60'(MOD_M);
   assign f2_rem  = f2_x_ff - 29'(f2_q_ff * MOD_D);
   assign f2_slot = f2_rem[SAW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff   <= 1'b0;
         f2_valid_ff   <= 1'b0;
         f3_valid_ff   <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         f1_valid_ff <= accept;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + SAW'(1);
            if (clr_addr_ff == SAW'(STAMP_DEPTH - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      f1_x_ff    <= x_in;
      f1_meta_ff <= in_meta;
      f2_x_ff    <= f1_x_ff;
      f2_q_ff    <= 29'(f1_prod >> MOD_K);
      f2_meta_ff <= f1_meta_ff;
      f3_meta_ff <= f2_meta_ff;
   end

   always_comb begin
      if (clr_active_ff) begin
         stamp_we    = 1'b1;
         stamp_waddr = clr_addr_ff;
         stamp_wdata = '0;
      end else begin
         stamp_we    = f2_valid_ff && (f2_meta_ff.kind == REQ_SEND);
         stamp_waddr = f2_slot;
         stamp_wdata = f2_meta_ff.tns;
      end
   end

   rtlm_ram #(
      .WIDTH (NS_W),
      .DEPTH (STAMP_DEPTH)
   ) u_stamp_ram (
      .clock      (clock),
      .wr_en      (stamp_we),
      .wr_addr    (stamp_waddr),
      .wr_data    (stamp_wdata),
      .rd_en      (f2_valid_ff),
      .rd_addr    (f2_slot),
      .rd_data_ff (stamp_rdata)
   );

   assign push            = f3_valid_ff;
   assign push_item.meta  = f3_meta_ff;
   assign push_item.stamp = stamp_rdata;

endmodule

/* design/rtlm_queue.sv */
// Short queue of classified items between the front and the back part.
module rtlm_queue
   import rtlm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  q_item_type        push_item,
   input  logic              pop,
   output q_item_type        head_item,
   output logic [QCNT_W-1:0] count
);

   localparam int QAW = $clog2(QUEUE_DEPTH);

   q_item_type        entry_ff [QUEUE_DEPTH];
   logic [QAW-1:0]    wr_ptr_ff;
   logic [QAW-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* design/rtlm_back.sv */
// Back part: latency arithmetic, running statistics, histogram and the result register.
module rtlm_back
   import rtlm_pkg::*;
#(
   parameter int HIST_BINS = HIST_BINS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic [QCNT_W-1:0]      q_count,
   input  q_item_type             q_head,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int HAW = $clog2(HIST_BINS);

   logic adv;

   logic              b1_valid_ff;
   q_item_type        b1_item_ff;
   logic signed [31:0] b1_d1;

   logic              b2_valid_ff;
   front_meta_type    b2_meta_ff;
   logic signed [31:0] b2_d1_ff;
   logic signed [31:0] b2_d2;
   logic              b2_live;
   logic [NS_W-1:0]   b2_lat;
   logic              b2_neg;

   logic              b3_valid_ff;
   front_meta_type    b3_meta_ff;
   logic [NS_W-1:0]   b3_lat_ff;
   logic              b3_neg_ff;
   logic [60:0]       b3_prod;
   logic              b3_upd;

   logic [NS_W-1:0]   min_ff, min_in;
   logic [NS_W-1:0]   max_ff, max_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ovf_ff, ovf_in;

   logic              b4_valid_ff;
   front_meta_type    b4_meta_ff;
   logic [NS_W-1:0]   b4_lat_ff;
   logic              b4_neg_ff;
   logic [60:0]       b4_prod_ff;
   logic [NS_W-1:0]   b4_min_ff;
   logic [NS_W-1:0]   b4_max_ff;
   logic [SUM_W-1:0]  b4_sum_ff;
   logic [CNT_W-1:0]  b4_count_ff;
   logic [US_W-1:0]   b4_us;
   logic [31:0]       b4_bidx_ext;
   logic              b4_live;
   logic              b4_in_range;
   logic              b4_inc;
   logic              b4_ovf;
   logic              b4_rd;
   logic [HAW-1:0]    b4_addr;

   logic              b5_valid_ff;
   front_meta_type    b5_meta_ff;
   logic [NS_W-1:0]   b5_lat_ff;
   logic              b5_neg_ff;
   logic [NS_W-1:0]   b5_min_ff;
   logic [NS_W-1:0]   b5_max_ff;
   logic [SUM_W-1:0]  b5_sum_ff;
   logic [CNT_W-1:0]  b5_count_ff;
   logic [CNT_W-1:0]  b5_ovf_ff;
   logic              b5_done_ff;
   logic              b5_inc_ff;
   logic              b5_rd_ff;
   logic [HAW-1:0]    b5_addr_ff;
   logic [CNT_W-1:0]  b5_old;
   logic [CNT_W-1:0]  b5_new;
   logic [CNT_W-1:0]  b5_bin;
   logic              b5_accepted;
   logic [RSP_TDATA_W-1:0] b5_packed;

   logic              lw_valid_ff;
   logic [HAW-1:0]    lw_addr_ff;
   logic [CNT_W-1:0]  lw_data_ff;

   logic              clr_active_ff;
   logic [HAW-1:0]    clr_addr_ff;

   logic              hist_we;
   logic [HAW-1:0]    hist_waddr;
   logic [CNT_W-1:0]  hist_wdata;
   logic [CNT_W-1:0]  hist_rdata;

   logic              rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // The whole back pipeline moves together whenever the result register can take an item.
   assign adv      = !rsp_valid_ff || rsp_tready;
   assign pop      = adv && (q_count != '0) && !clr_active_ff;
   assign clearing = clr_active_ff;

   // Receive time minus send time, with one second added when it wraps.
   always_comb begin
      b1_d1 = $signed({2'b00, b1_item_ff.meta.tns}) - $signed({2'b00, b1_item_ff.stamp});
      if (b1_d1 < 0) begin
         b1_d1 = b1_d1 + NS_PER_S;
      end
   end

   assign b2_live = (b2_meta_ff.kind == REQ_RECV) && b2_meta_ff.ok;
   assign b2_d2   = b2_d1_ff - $signed({2'b00, b2_meta_ff.hold});

   always_comb begin
      b2_lat = '0;
      b2_neg = 1'b0;
      if (b2_live) begin
         if (b2_d2 < 0) begin
            b2_neg = 1'b1;
         end else if (b2_d2 > $signed({2'b00, LAT_MAX})) begin
            b2_lat = LAT_MAX;
         end else begin
            b2_lat = b2_d2[NS_W-1:0];
         end
      end
   end

   assign b3_upd  = b3_valid_ff && (b3_meta_ff.kind == REQ_RECV) && b3_meta_ff.ok;
   assign b3_prod = 61'(b3_lat_ff) * 61'(DIV_US_MULT);

   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (b3_upd) begin
         if (b3_lat_ff < min_ff) begin
            min_in = b3_lat_ff;
         end
         if (b3_lat_ff > max_ff) begin
            max_in = b3_lat_ff;
         end
         sum_in   = sum_ff + SUM_W'(b3_lat_ff);
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign b4_us       = b4_prod_ff[DIV_US_SHIFT +: US_W];
   assign b4_bidx_ext = 32'(b4_meta_ff.bin_index);
   assign b4_live     = b4_valid_ff && (b4_meta_ff.kind == REQ_RECV) && b4_meta_ff.ok
                      && cfg.hist_enable;
   assign b4_in_range = 32'(b4_us) < 32'(HIST_BINS);
   assign b4_inc      = b4_live && b4_in_range;
   assign b4_ovf      = b4_live && !b4_in_range;
   assign b4_rd       = b4_valid_ff && (b4_meta_ff.kind == REQ_READ)
                      && (b4_bidx_ext < 32'(HIST_BINS));
   assign b4_addr     = b4_inc ? b4_us[HAW-1:0] : b4_bidx_ext[HAW-1:0];
   assign ovf_in      = b4_ovf ? ovf_ff + CNT_W'(1) : ovf_ff;

   // The write of the item just ahead lands in the same cycle as this item's read.
   assign b5_old = (lw_valid_ff && (lw_addr_ff == b5_addr_ff)) ? lw_data_ff : hist_rdata;
   assign b5_new = b5_old + CNT_W'(1);

   always_comb begin
      b5_bin = '0;
      if (b5_inc_ff) begin
         b5_bin = b5_new;
      end else if (b5_rd_ff) begin
         b5_bin = b5_old;
      end
   end

   assign b5_accepted = (b5_meta_ff.kind == REQ_SEND)
                      || ((b5_meta_ff.kind == REQ_RECV) && b5_meta_ff.ok);

   always_comb begin
      b5_packed          = '0;
      b5_packed[0]       = b5_accepted;
      b5_packed[30:1]    = b5_lat_ff;
      b5_packed[31]      = b5_neg_ff;
      b5_packed[61:32]   = b5_min_ff;
      b5_packed[91:62]   = b5_max_ff;
      b5_packed[155:92]  = b5_sum_ff;
      b5_packed[187:156] = b5_count_ff;
      b5_packed[219:188] = b5_ovf_ff;
      b5_packed[220]     = b5_done_ff;
      b5_packed[252:221] = b5_bin;
   end

   always_comb begin
      if (clr_active_ff) begin
         hist_we    = 1'b1;
         hist_waddr = clr_addr_ff;
         hist_wdata = '0;
      end else begin
         hist_we    = adv && b5_valid_ff && b5_inc_ff;
         hist_waddr = b5_addr_ff;
         hist_wdata = b5_new;
      end
   end

   rtlm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_BINS)
   ) u_hist_ram (
      .clock      (clock),
      .wr_en      (hist_we),
      .wr_addr    (hist_waddr),
      .wr_data    (hist_wdata),
      .rd_en      (adv && (b4_inc || b4_rd)),
      .rd_addr    (b4_addr),
      .rd_data_ff (hist_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff   <= 1'b0;
         b2_valid_ff   <= 1'b0;
         b3_valid_ff   <= 1'b0;
         b4_valid_ff   <= 1'b0;
         b5_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         lw_valid_ff   <= 1'b0;
         min_ff        <= LAT_MAX;
         max_ff        <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         ovf_ff        <= '0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + HAW'(1);
            if (clr_addr_ff == HAW'(HIST_BINS - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         if (adv) begin
            b1_valid_ff  <= pop;
            b2_valid_ff  <= b1_valid_ff;
            b3_valid_ff  <= b2_valid_ff;
            b4_valid_ff  <= b3_valid_ff;
            b5_valid_ff  <= b4_valid_ff;
            rsp_valid_ff <= b5_valid_ff;
            lw_valid_ff  <= b5_valid_ff && b5_inc_ff;
            min_ff       <= min_in;
            max_ff       <= max_in;
            sum_ff       <= sum_in;
            count_ff     <= count_in;
            ovf_ff       <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_item_ff  <= q_head;
         b2_meta_ff  <= b1_item_ff.meta;
         b2_d1_ff    <= b1_d1;
         b3_meta_ff  <= b2_meta_ff;
         b3_lat_ff   <= b2_lat;
         b3_neg_ff   <= b2_neg;
         b4_meta_ff  <= b3_meta_ff;
         b4_lat_ff   <= b3_lat_ff;
         b4_neg_ff   <= b3_neg_ff;
         b4_prod_ff  <= b3_prod;
         b4_min_ff   <= min_in;
         b4_max_ff   <= max_in;
         b4_sum_ff   <= sum_in;
         b4_count_ff <= count_in;
         b5_meta_ff  <= b4_meta_ff;
         b5_lat_ff   <= b4_lat_ff;
         b5_neg_ff   <= b4_neg_ff;
         b5_min_ff   <= b4_min_ff;
         b5_max_ff   <= b4_max_ff;
         b5_sum_ff   <= b4_sum_ff;
         b5_count_ff <= b4_count_ff;
         b5_ovf_ff   <= ovf_in;
         b5_done_ff  <= (cfg.max_count != '0) && (b4_count_ff >= cfg.max_count);
         b5_inc_ff   <= b4_inc;
         b5_rd_ff    <= b4_rd;
         b5_addr_ff  <= b4_addr;
         lw_addr_ff  <= b5_addr_ff;
         lw_data_ff  <= b5_new;
         rsp_data_ff <= b5_packed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sim/round_trip_latency_monitor_unit_test.sv */
// Self-checking testbench of the round trip latency monitor, with its own latency predictor.
module round_trip_latency_monitor_unit_test;
   import rtlm_pkg::*;

   localparam int STAMP_DEPTH = STAMP_DEPTH_DEF;
   localparam int HIST_BINS   = HIST_BINS_DEF;
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   localparam longint NS_IN_SECOND  = 1000000000;
   localparam longint NS_IN_US      = 1000;
   localparam longint LATENCY_CEIL  = 999999999;
   localparam int     SETTLE_CYCLES = 20;
   localparam int     MAX_PRINTED   = 40;

   typedef struct packed {
      logic             pad;
      logic [BIN_W-1:0] bin_index;
      logic             tag_ok;
      logic [NS_W-1:0]  hold_ns;
      logic [MAC_W-1:0] src_mac;
      logic [NS_W-1:0]  time_ns;
      logic [SEQ_W-1:0] seq_num;
   } probe_item_type;

   typedef struct packed {
      logic [2:0]       pad;
      logic [CNT_W-1:0] bin_count;
      logic             done_res;
      logic [CNT_W-1:0] overflow_count;
      logic [CNT_W-1:0] reply_count;
      logic [SUM_W-1:0] sum_ns;
      logic [NS_W-1:0]  max_ns;
      logic [NS_W-1:0]  min_ns;
      logic             neg_flag;
      logic [NS_W-1:0]  latency_ns;
      logic             accepted;
   } latency_report_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_AW-1:0]      csr_addr;
   logic [CSR_DW-1:0]      csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // seq_num, time_ns, src_mac, hold_ns, tag_ok, bin_index
   logic [REQ_TDATA_W-1:0] req_tdata;
   // req_type
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // accepted, latency_ns, neg_flag, min_ns, max_ns, sum_ns, reply_count,
   // overflow_count, done_res, bin_count
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Predicted state of the monitor.
   logic [NS_W-1:0]  stamp_mem [STAMP_DEPTH];
   logic [CNT_W-1:0] hist_mem [HIST_BINS];
   logic [NS_W-1:0]  lat_min;
   logic [NS_W-1:0]  lat_max;
   logic [SUM_W-1:0] lat_sum;
   logic [CNT_W-1:0] reply_total;
   logic [CNT_W-1:0] overflow_total;
   cfg_type          model_cfg;

   latency_report_type expected_reports[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int items_sent;
   int results_checked;
   int replies_counted;
   int negatives_seen;
   int overflows_seen;
   int bins_bumped;
   int reads_done;

   round_trip_latency_monitor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("** round_trip_latency_monitor_unit: FAILED **");
      $finish;
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic latency_report_type predict_report(logic [KIND_W-1:0] kind,
                                                         probe_item_type it);
      latency_report_type r;
      longint             span;
      longint             us;
      int unsigned        slot;
      r = '0;
      slot = it.seq_num % STAMP_DEPTH;
      case (kind)
         REQ_SEND: begin
            stamp_mem[slot] = it.time_ns;
            r.accepted = 1'b1;
         end
         REQ_RECV: begin
            if (it.src_mac == model_cfg.peer_mac && it.tag_ok) begin
               span = longint'(it.time_ns) - longint'(stamp_mem[slot]);
               if (span < 0) span += NS_IN_SECOND;
               span -= longint'(it.hold_ns);
               if (span < 0) begin
                  span = 0;
                  r.neg_flag = 1'b1;
                  negatives_seen++;
               end
               if (span > LATENCY_CEIL) span = LATENCY_CEIL;
               r.accepted = 1'b1;
               r.latency_ns = NS_W'(span);
               if (r.latency_ns > lat_max) lat_max = r.latency_ns;
               if (r.latency_ns < lat_min) lat_min = r.latency_ns;
               lat_sum = lat_sum + SUM_W'(span);
               reply_total = reply_total + CNT_W'(1);
               replies_counted++;
               if (model_cfg.hist_enable) begin
                  us = span / NS_IN_US;
                  if (us < HIST_BINS) begin
                     hist_mem[us] = hist_mem[us] + CNT_W'(1);
                     r.bin_count = hist_mem[us];
                     bins_bumped++;
                  end else begin
                     overflow_total = overflow_total + CNT_W'(1);
                     overflows_seen++;
                  end
               end
            end
         end
         REQ_READ: begin
            if (it.bin_index < HIST_BINS) r.bin_count = hist_mem[it.bin_index];
            reads_done++;
         end
         default: ;
      endcase
      r.min_ns = lat_min;
      r.max_ns = lat_max;
      r.sum_ns = lat_sum;
      r.reply_count = reply_total;
      r.overflow_count = overflow_total;
      r.done_res = (model_cfg.max_count != '0) && (reply_total >= model_cfg.max_count);
      return r;
   endfunction

   function automatic probe_item_type make_item(logic [SEQ_W-1:0] seq, logic [NS_W-1:0] tns,
                                                logic [MAC_W-1:0] mac, logic [NS_W-1:0] hold,
                                                logic tag, logic [BIN_W-1:0] bin);
      probe_item_type it;
      it = '0;
      it.seq_num = seq;
      it.time_ns = tns;
      it.src_mac = mac;
      it.hold_ns = hold;
      it.tag_ok = tag;
      it.bin_index = bin;
      return it;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch in %s of result %0d: got %0h, expected %0h",
                  field, results_checked, got, want);
   endtask

   always @(posedge clock) begin : check_reports
      latency_report_type got;
      latency_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_reports.size() == 0) begin
            report_mismatch("result with nothing expected", 64'd1, 64'd0);
         end else begin
            want = expected_reports.pop_front();
            if (got.accepted !== want.accepted)
               report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
            if (got.latency_ns !== want.latency_ns)
               report_mismatch("latency_ns", 64'(got.latency_ns), 64'(want.latency_ns));
            if (got.neg_flag !== want.neg_flag)
               report_mismatch("neg_flag", 64'(got.neg_flag), 64'(want.neg_flag));
            if (got.min_ns !== want.min_ns)
               report_mismatch("min_ns", 64'(got.min_ns), 64'(want.min_ns));
            if (got.max_ns !== want.max_ns)
               report_mismatch("max_ns", 64'(got.max_ns), 64'(want.max_ns));
            if (got.sum_ns !== want.sum_ns)
               report_mismatch("sum_ns", got.sum_ns, want.sum_ns);
            if (got.reply_count !== want.reply_count)
               report_mismatch("reply_count", 64'(got.reply_count), 64'(want.reply_count));
            if (got.overflow_count !== want.overflow_count)
               report_mismatch("overflow_count", 64'(got.overflow_count),
                               64'(want.overflow_count));
            if (got.done_res !== want.done_res)
               report_mismatch("done_res", 64'(got.done_res), 64'(want.done_res));
            if (got.bin_count !== want.bin_count)
               report_mismatch("bin_count", 64'(got.bin_count), 64'(want.bin_count));
         end
         results_checked++;
      end
   end

   task automatic send_item(logic [KIND_W-1:0] kind, probe_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = it;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_reports.push_back(predict_report(kind, it));
      items_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_PEER_MAC:    model_cfg.peer_mac = value[MAC_W-1:0];
         CSR_HIST_ENABLE: model_cfg.hist_enable = value[0];
         CSR_MAX_COUNT:   model_cfg.max_count = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic test_special_cases();
      logic [MAC_W-1:0] peer;
      peer = 48'h0200_0000_00AB;
      send_idle_pct = 16;
      recv_idle_pct = 76;
      write_csr(CSR_PEER_MAC, CSR_DW'(peer));
      write_csr(CSR_HIST_ENABLE, CSR_DW'(1));
      write_csr(CSR_MAX_COUNT, CSR_DW'(3));
      // Sends at both ends of every field; the second one lands in the last slot.
      send_item(REQ_SEND, make_item('0, '0, '0, '0, 1'b0, '0));
      send_item(REQ_SEND, make_item('1, 30'd999999999, '1, '1, 1'b1, '1));
      send_item(REQ_RECV, make_item(32'd128, 30'd5000, peer, 30'd1000, 1'b1, '0));
      // Receive nanoseconds below the send nanoseconds, so a second is added.
      send_item(REQ_RECV, make_item(32'hFFFF_FF7F, 30'd1500, peer, '0, 1'b1, '0));
      send_item(REQ_RECV, make_item(32'd128, 30'd5000, peer ^ 48'h1, '0, 1'b1, '0));
      send_item(REQ_RECV, make_item(32'd128, 30'd5000, peer, '0, 1'b0, '0));
      // The hold time exceeds the round trip; this reply also reaches the done count.
      send_item(REQ_SEND, make_item(32'd5, 30'd1000, '0, '0, 1'b0, '0));
      send_item(REQ_RECV, make_item(32'd5, 30'd2000, peer, 30'd5000, 1'b1, '0));
      // A receive time outside its range saturates, then a plain overflow.
      send_item(REQ_SEND, make_item(32'd6, '0, '0, '0, 1'b0, '0));
      send_item(REQ_RECV, make_item(32'd6, '1, peer, '0, 1'b1, '0));
      send_item(REQ_RECV, make_item(32'd6, 30'd2000000, peer, '0, 1'b1, '0));
      send_item(REQ_SEND, make_item(32'd9, '0, '0, '0, 1'b0, '0));
      send_item(REQ_RECV, make_item(32'd9, 30'd1023500, peer, '0, 1'b1, '0));
      send_item(REQ_READ, make_item('0, '0, '0, '0, 1'b0, 10'd4));
      send_item(REQ_READ, make_item('0, '0, '0, '0, 1'b0, 10'd0));
      send_item(REQ_READ, make_item('0, '0, '0, '0, 1'b0, 10'd1));
      send_item(REQ_READ, make_item('1, '1, '1, '1, 1'b1, '1));
      send_item(REQ_READ, make_item('0, '0, '0, '0, 1'b0, 10'd512));
      send_item(REQ_UNUSED, make_item('1, '1, '1, '1, 1'b1, '1));
      wait_for_results();
      // With binning off a reply leaves the histogram and the overflow count alone.
      write_csr(CSR_HIST_ENABLE, CSR_DW'(0));
      write_csr(CSR_PEER_MAC, '1);
      send_item(REQ_RECV, make_item('0, 30'd3000, '1, '0, 1'b1, '0));
      send_item(REQ_READ, make_item('0, '0, '0, '0, 1'b0, 10'd3));
      send_item(REQ_RECV, make_item('0, '1, '1, '1, 1'b1, '1));
      wait_for_results();
   endtask

   task automatic test_random_traffic(int count, int s_pct, int r_pct,
                                      logic [MAC_W-1:0] peer, logic hist_on,
                                      logic [CNT_W-1:0] done_at);
      int                useful;
      int                pick;
      bit                paused;
      logic [KIND_W-1:0] kind;
      probe_item_type    it;
      longint            lat;
      longint            hold;
      longint            arrive;
      wait_for_results();
      write_csr(CSR_PEER_MAC, CSR_DW'(peer));
      write_csr(CSR_HIST_ENABLE, CSR_DW'(hist_on));
      write_csr(CSR_MAX_COUNT, CSR_DW'(done_at));
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      useful = 0;
      paused = 1'b0;
      while (useful < count) begin
         // Halfway through, hold the stream until the monitor has answered everything.
         if (!paused && useful >= count / 2) begin
            paused = 1'b1;
            wait_for_results();
         end
         it = '0;
         it.seq_num = $urandom;
         it.time_ns = NS_W'($urandom);
         it.src_mac = {16'($urandom), 32'($urandom)};
         it.hold_ns = NS_W'($urandom);
         it.tag_ok = 1'($urandom);
         it.bin_index = BIN_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 30) begin
            kind = REQ_SEND;
            if ($urandom_range(9) != 0) it.time_ns = NS_W'($urandom_range(0, 999999999));
         end else if (pick < 70) begin
            kind = REQ_RECV;
            it.src_mac = peer;
            it.tag_ok = 1'b1;
            pick = $urandom_range(99);
            if (pick < 70) lat = longint'($urandom_range(0, 1030000));
            else if (pick < 90) lat = longint'($urandom_range(0, 20000));
            else lat = longint'($urandom_range(0, 999999999));
            hold = ($urandom_range(3) == 0) ? 64'sd0 : longint'($urandom_range(0, 500000));
            arrive = (longint'(stamp_mem[it.seq_num % STAMP_DEPTH]) + lat + hold)
                     % NS_IN_SECOND;
            it.time_ns = NS_W'(arrive);
            if ($urandom_range(9) == 0) hold += lat + longint'($urandom_range(1, 200000));
            it.hold_ns = NS_W'(hold);
         end else if (pick < 80) begin
            kind = REQ_READ;
            if ($urandom_range(1) == 0) it.bin_index = BIN_W'($urandom_range(0, 40));
         end else begin
            kind = KIND_W'($urandom);
            if ($urandom_range(1) == 0)
               it.src_mac = peer ^ (48'h1 << $urandom_range(0, MAC_W - 1));
            else if ($urandom_range(1) == 0)
               it.src_mac = peer;
         end
         send_item(kind, it);
         if (!(kind == REQ_UNUSED ||
               (kind == REQ_RECV && !(it.src_mac == peer && it.tag_ok))))
            useful++;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = CSR_PEER_MAC;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_SEND;
      rsp_tready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      mismatch_count = 0;
      items_sent = 0;
      results_checked = 0;
      replies_counted = 0;
      negatives_seen = 0;
      overflows_seen = 0;
      bins_bumped = 0;
      reads_done = 0;
      foreach (stamp_mem[i]) stamp_mem[i] = '0;
      foreach (hist_mem[i]) hist_mem[i] = '0;
      lat_min = LAT_MAX;
      lat_max = '0;
      lat_sum = '0;
      reply_total = '0;
      overflow_total = '0;
      model_cfg = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_cases();
      test_random_traffic(405, 16, 76, {16'($urandom), 32'($urandom)}, 1'b1, '0);
      test_random_traffic(360, 76, 16, '1, 1'b0, '1);
      test_random_traffic(450, 0, 0, '0, 1'b1, reply_total + CNT_W'(150));
      wait_for_results();

      $display("Sent %0d items and checked %0d results: %0d replies counted, %0d negative.",
               items_sent, results_checked, replies_counted, negatives_seen);
      $display("Histogram: %0d bin increments, %0d overflows, %0d bin reads.",
               bins_bumped, overflows_seen, reads_done);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("** round_trip_latency_monitor_unit: PASSED **");
      end else begin
         $display("** round_trip_latency_monitor_unit: FAILED **");
      end
      $finish;
   end

endmodule
